/* hdl/aqlb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aqlb_pkg
// Shared types and constants of the air quality LED bar meter: channel
// payloads, register map, divider lane format and the per-reading LED item.
// ----------------------------------------------------------------------------
package aqlb_pkg;

   // default parameter values
   localparam int NUM_LEDS_DEF  = 12;
   localparam int FRAC_BITS_DEF = 16;

   // fixed field widths
   localparam int THR_W      = 16;
   localparam int COLOR_W    = 8;
   localparam int HUE_W      = 15;
   localparam int LED_IDX_W  = 6;
   localparam int EDGE_W     = LED_IDX_W + 1;
   localparam int REM_W      = THR_W + 1;
   localparam int DIV_W      = THR_W + 1;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = THR_W;

   // hue of a fully severe reading (red)
   localparam logic [HUE_W-1:0] HUE_RED = 15'd22027;

   // divider lanes: fill and severity for each gas
   localparam int NUM_LANES      = 4;
   localparam int LANE_CO2_FILL  = 0;
   localparam int LANE_TVOC_FILL = 1;
   localparam int LANE_CO2_SEV   = 2;
   localparam int LANE_TVOC_SEV  = 3;

   // register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CO2_LOW    = 3'd0,
      CSR_CO2_HIGH   = 3'd1,
      CSR_TVOC_LOW   = 3'd2,
      CSR_TVOC_HIGH  = 3'd3,
      CSR_BRIGHTNESS = 3'd4,
      CSR_SATURATION = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic [THR_W-1:0]   co2_low;
      logic [THR_W-1:0]   co2_high;
      logic [THR_W-1:0]   tvoc_low;
      logic [THR_W-1:0]   tvoc_high;
      logic [COLOR_W-1:0] brightness;
      logic [COLOR_W-1:0] saturation;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      co2_low:    16'd1000,
      co2_high:   16'd2000,
      tvoc_low:   16'd220,
      tvoc_high:  16'd660,
      brightness: 8'd255,
      saturation: 8'd255
   };

   // channel payloads
   typedef struct packed {
      logic [THR_W-1:0] co2_ppm;
      logic [THR_W-1:0] tvoc_ppb;
   } req_type;

   typedef struct packed {
      logic [LED_IDX_W-1:0] led_index;
      logic [HUE_W-1:0]     hue;
      logic [COLOR_W-1:0]   sat_out;
      logic [COLOR_W-1:0]   val_out;
      logic                 last;
   } rsp_type;

   // one divider lane: partial remainder, divisor, saturated-to-one flag
   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [DIV_W-1:0] dvs;
      logic             sat;
   } div_lane_type;

   // per-reading summary handed to the LED serializer
   typedef struct packed {
      logic               any;
      logic [EDGE_W-1:0]  edge_pos;
      logic [HUE_W-1:0]   hue;
      logic [COLOR_W-1:0] edge_val;
   } led_item_type;

endpackage : aqlb_pkg
`default_nettype wire

/* hdl/aqlb_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aqlb_front
// Input stage: sorts each gas reading against its thresholds and sets up the
// four divider lanes (remainder and divisor, or a forced zero or one).
// ----------------------------------------------------------------------------
module aqlb_front
   import aqlb_pkg::*;
(
   input  wire                                 clock,
   input  wire                                 reset,
   input  cfg_type                             cfg,
   input  wire                                 in_valid,
   output logic                                in_ready,
   input  req_type                             in_data,
   output logic                                out_valid,
   input  wire                                 out_ready,
   output div_lane_type [NUM_LANES-1:0]        out_lane
);

   logic                         vld_ff;
   logic                         vld_in;
   logic                         adv;
   div_lane_type [NUM_LANES-1:0] lane_ff;
   div_lane_type [NUM_LANES-1:0] lane_in;

   // fill: zero below low, one from twice high, else (v-low)/(2*high-low)
   function automatic div_lane_type fill_lane(input logic [THR_W-1:0] v,
                                              input logic [THR_W-1:0] lo,
                                              input logic [THR_W-1:0] hi);
      logic [DIV_W-1:0] hi2;
      div_lane_type     r;
      hi2   = {hi, 1'b0};
      r.rem = '0;
      r.dvs = DIV_W'(1);
      r.sat = 1'b0;
      if (v >= lo) begin
         if ({1'b0, v} >= hi2) begin
            r.sat = 1'b1;
         end else begin
            r.rem = {1'b0, v - lo};
            r.dvs = hi2 - {1'b0, lo};
         end
      end
      return r;
   endfunction

   // severity: zero below high, one from twice high, else (v-high)/high
   function automatic div_lane_type sev_lane(input logic [THR_W-1:0] v,
                                             input logic [THR_W-1:0] hi);
      div_lane_type r;
      r.rem = '0;
      r.dvs = DIV_W'(1);
      r.sat = 1'b0;
      if (v >= hi) begin
         if ({1'b0, v} >= {hi, 1'b0}) begin
            r.sat = 1'b1;
         end else begin
            r.rem = {1'b0, v - hi};
            r.dvs = {1'b0, hi};
         end
      end
      return r;
   endfunction

   // stage handshake
   assign adv      = !vld_ff || out_ready;
   assign in_ready = adv;
   assign vld_in   = adv ? in_valid : vld_ff;

   // lane setup
   always_comb begin
      lane_in                 = lane_ff;
      lane_in[LANE_CO2_FILL]  = fill_lane(in_data.co2_ppm, cfg.co2_low, cfg.co2_high);
      lane_in[LANE_TVOC_FILL] = fill_lane(in_data.tvoc_ppb, cfg.tvoc_low, cfg.tvoc_high);
      lane_in[LANE_CO2_SEV]   = sev_lane(in_data.co2_ppm, cfg.co2_high);
      lane_in[LANE_TVOC_SEV]  = sev_lane(in_data.tvoc_ppb, cfg.tvoc_high);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lane_ff <= lane_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_lane  = lane_ff;

endmodule : aqlb_front
`default_nettype wire

/* hdl/aqlb_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aqlb_div
// Pipelined restoring divider, four lanes side by side, one quotient bit per
// stage. Produces the fill and severity levels as fixed point, 1.0 = 2^FRAC.
// ----------------------------------------------------------------------------
module aqlb_div
   import aqlb_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       in_valid,
   output logic                                      in_ready,
   input  div_lane_type [NUM_LANES-1:0]              in_lane,
   output logic                                      out_valid,
   input  wire                                       out_ready,
   output logic [NUM_LANES-1:0][FRAC_BITS:0]         out_level
);

   localparam logic [FRAC_BITS:0] LVL_ONE = {1'b1, {FRAC_BITS{1'b0}}};
   localparam int                 LAST    = FRAC_BITS - 1;

   logic                                  vld_ff  [FRAC_BITS];
   logic                                  adv     [FRAC_BITS];
   div_lane_type [NUM_LANES-1:0]          lane_ff [FRAC_BITS];
   logic [NUM_LANES-1:0][FRAC_BITS-1:0]   quo_ff  [FRAC_BITS];

   for (genvar s = 0; s < FRAC_BITS; s++) begin : g_stage
      logic                                src_vld;
      div_lane_type [NUM_LANES-1:0]        src_lane;
      logic [NUM_LANES-1:0][FRAC_BITS-1:0] src_quo;
      logic                                nxt_ready;
      logic                                vld_in;
      div_lane_type [NUM_LANES-1:0]        lane_in;
      logic [NUM_LANES-1:0][FRAC_BITS-1:0] quo_in;

      // source of this stage
      if (s == 0) begin : g_head
         assign src_vld  = in_valid;
         assign src_lane = in_lane;
         assign src_quo  = '0;
      end else begin : g_body
         assign src_vld  = vld_ff[s-1];
         assign src_lane = lane_ff[s-1];
         assign src_quo  = quo_ff[s-1];
      end

      // downstream ready
      if (s == LAST) begin : g_tail
         assign nxt_ready = out_ready;
      end else begin : g_link
         assign nxt_ready = adv[s+1];
      end

      assign adv[s] = !vld_ff[s] || nxt_ready;
      assign vld_in = adv[s] ? src_vld : vld_ff[s];

      // one restoring step per lane
      for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
         logic [REM_W:0]   shf;
         logic [REM_W+1:0] dif;
         logic             take;
         assign shf        = {src_lane[l].rem, 1'b0};
         assign dif        = {1'b0, shf} - {2'b00, src_lane[l].dvs};
         assign take       = ~dif[REM_W+1];
         assign lane_in[l] = '{rem: (take ? dif[REM_W-1:0] : shf[REM_W-1:0]),
                               dvs: src_lane[l].dvs,
                               sat: src_lane[l].sat};
         assign quo_in[l]  = {src_quo[l][FRAC_BITS-2:0], take};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= vld_in;
         end
      end

      always_ff @(posedge clock) begin
         if (adv[s]) begin
            lane_ff[s] <= lane_in;
            quo_ff[s]  <= quo_in;
         end
      end
   end

   // result levels, saturated lanes read as one
   for (genvar l = 0; l < NUM_LANES; l++) begin : g_out
      assign out_level[l] = lane_ff[LAST][l].sat ? LVL_ONE : {1'b0, quo_ff[LAST][l]};
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[LAST];

   // remainder never reaches the divisor at the end of the pipe
   for (genvar l = 0; l < NUM_LANES; l++) begin : g_chk
      a_rem_below_dvs: assert property (@(posedge clock) disable iff (reset)
         vld_ff[LAST] |-> (lane_ff[LAST][l].rem < lane_ff[LAST][l].dvs))
         else $error("divider remainder not below divisor");
   end

endmodule : aqlb_div
`default_nettype wire

/* hdl/aqlb_mix.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aqlb_mix
// Three stages: max over both gases, scale by LED count and hue range, then
// split into edge position and fraction and weight the edge brightness.
// ----------------------------------------------------------------------------
module aqlb_mix
   import aqlb_pkg::*;
#(
   parameter int NUM_LEDS  = NUM_LEDS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  wire                                clock,
   input  wire                                reset,
   input  cfg_type                            cfg,
   input  wire                                in_valid,
   output logic                               in_ready,
   input  wire  [NUM_LANES-1:0][FRAC_BITS:0]  in_level,
   output logic                               out_valid,
   input  wire                                out_ready,
   output led_item_type                       out_item
);

   localparam int LVL_W = FRAC_BITS + 1;
   localparam int SC_W  = FRAC_BITS + EDGE_W;
   localparam int HP_W  = LVL_W + HUE_W;
   localparam int EV_W  = FRAC_BITS + COLOR_W;

   logic               v1_ff, v2_ff, v3_ff;
   logic               v1_in, v2_in, v3_in;
   logic               en1, en2, en3;
   logic [LVL_W-1:0]   p_ff, p_in;
   logic [LVL_W-1:0]   s_ff, s_in;
   logic [SC_W-1:0]    scl_ff, scl_in;
   logic [HP_W-1:0]    hprod_ff, hprod_in;
   logic               any_ff, any_in;
   logic [EV_W-1:0]    ev_prod;
   led_item_type       item_ff, item_in;

   // stage enables
   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;
   assign v1_in    = en1 ? in_valid : v1_ff;
   assign v2_in    = en2 ? v1_ff : v2_ff;
   assign v3_in    = en3 ? v2_ff : v3_ff;

   // stage 1: maximum over both gases
   assign p_in = (in_level[LANE_CO2_FILL] > in_level[LANE_TVOC_FILL]) ?
                 in_level[LANE_CO2_FILL] : in_level[LANE_TVOC_FILL];
   assign s_in = (in_level[LANE_CO2_SEV] > in_level[LANE_TVOC_SEV]) ?
                 in_level[LANE_CO2_SEV] : in_level[LANE_TVOC_SEV];

   // stage 2: scale fill by LED count and severity by hue range
   assign scl_in   = SC_W'(p_ff) * SC_W'(NUM_LEDS);
   assign hprod_in = HP_W'(s_ff) * HP_W'(HUE_RED);
   assign any_in   = (p_ff != '0);

   // stage 3: edge position, fraction brightness, hue
   assign ev_prod = EV_W'(scl_ff[FRAC_BITS-1:0]) * EV_W'(cfg.brightness);
   always_comb begin
      item_in.any      = any_ff;
      item_in.edge_pos = scl_ff[SC_W-1:FRAC_BITS];
      item_in.hue      = hprod_ff[FRAC_BITS+HUE_W-1:FRAC_BITS];
      item_in.edge_val = ev_prod[EV_W-1:FRAC_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         p_ff <= p_in;
         s_ff <= s_in;
      end
      if (en2) begin
         scl_ff   <= scl_in;
         hprod_ff <= hprod_in;
         any_ff   <= any_in;
      end
      if (en3) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_item  = item_ff;

   // edge never lies beyond the bar
   a_edge_in_bar: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (item_ff.edge_pos <= EDGE_W'(NUM_LEDS)))
      else $error("edge position beyond bar length");

   // an empty bar has its edge at the start
   a_empty_edge: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !item_ff.any) |-> (item_ff.edge_pos == '0))
      else $error("empty bar with nonzero edge");

endmodule : aqlb_mix
`default_nettype wire

/* hdl/aqlb_serial.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// aqlb_serial
// LED serializer: holds one reading summary and walks the bar, one LED color
// per transfer into the output register, marking the last LED.
// ----------------------------------------------------------------------------
module aqlb_serial
   import aqlb_pkg::*;
#(
   parameter int NUM_LEDS = NUM_LEDS_DEF
)
(
   input  wire          clock,
   input  wire          reset,
   input  cfg_type      cfg,
   input  wire          in_valid,
   output logic         in_ready,
   input  led_item_type in_item,
   output logic         rsp_valid,
   input  wire          rsp_stall,
   output rsp_type      rsp_data
);

   localparam logic [LED_IDX_W-1:0] LAST_IDX = LED_IDX_W'(NUM_LEDS - 1);

   logic                 slot_vld_ff, slot_vld_in;
   led_item_type         slot_ff;
   logic [LED_IDX_W-1:0] cnt_ff, cnt_in;
   logic                 out_vld_ff, out_vld_in;
   rsp_type              out_ff, out_in;
   logic                 out_load;
   logic                 step;
   logic                 at_last;
   logic                 in_xfer;
   logic                 lit;
   logic                 full;

   // handshake
   assign out_load = !out_vld_ff || !rsp_stall;
   assign step     = slot_vld_ff && out_load;
   assign at_last  = (cnt_ff == LAST_IDX);
   assign in_ready = !slot_vld_ff || (step && at_last);
   assign in_xfer  = in_valid && in_ready;

   assign slot_vld_in = in_xfer ? 1'b1 : ((step && at_last) ? 1'b0 : slot_vld_ff);
   assign cnt_in      = step ? (at_last ? '0 : cnt_ff + 1'b1) : cnt_ff;
   assign out_vld_in  = out_load ? slot_vld_ff : out_vld_ff;

   // color of the current LED
   assign lit  = slot_ff.any && ({1'b0, cnt_ff} <= slot_ff.edge_pos);
   assign full = ({1'b0, cnt_ff} < slot_ff.edge_pos);
   always_comb begin
      out_in.led_index = cnt_ff;
      out_in.hue       = lit ? slot_ff.hue : '0;
      out_in.sat_out   = lit ? cfg.saturation : '0;
      out_in.val_out   = lit ? (full ? cfg.brightness : slot_ff.edge_val) : '0;
      out_in.last      = at_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_vld_ff <= 1'b0;
         cnt_ff      <= '0;
         out_vld_ff  <= 1'b0;
      end else begin
         slot_vld_ff <= slot_vld_in;
         cnt_ff      <= cnt_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_xfer) begin
         slot_ff <= in_item;
      end
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   // last flag only on the final LED
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && out_ff.last) |-> (out_ff.led_index == LAST_IDX))
      else $error("last flag on wrong LED");

   // counter rests at zero while no reading is held
   a_idle_cnt: assert property (@(posedge clock) disable iff (reset)
      !slot_vld_ff |-> (cnt_ff == '0))
      else $error("LED counter not cleared with empty slot");

endmodule : aqlb_serial
`default_nettype wire

/* hdl/air_quality_led_bar_meter_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// air_quality_led_bar_meter_top
// Turns one CO2 and one tVOC reading into a run of HSV colors for an LED bar.
// ----------------------------------------------------------------------------
// Each accepted reading yields NUM_LEDS result transfers, LED 0 first, the
// final one flagged with last. A reading walks a pipeline of 1 input stage,
// FRAC_BITS divider stages (one quotient bit each) and 3 scaling stages;
// readings may be accepted in consecutive cycles until the pipeline fills.
// The sustained rate is one LED per cycle while rsp_stall is low, set by the
// serializer that drives the result port.
// Register writes are accepted every cycle and should only be issued while
// no reading is in flight.
// ----------------------------------------------------------------------------
module air_quality_led_bar_meter_top
   import aqlb_pkg::*;
#(
   parameter int NUM_LEDS  = NUM_LEDS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output rsp_type                rsp_data,
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire [CSR_IDX_W-1:0]    csr_index,
   input  wire [CSR_DATA_W-1:0]   csr_wdata
);

   cfg_type                            cfg_ff, cfg_in;
   logic                               front_ready;
   logic                               front_valid;
   div_lane_type [NUM_LANES-1:0]       front_lane;
   logic                               div_ready;
   logic                               div_valid;
   logic [NUM_LANES-1:0][FRAC_BITS:0]  div_level;
   logic                               mix_ready;
   logic                               mix_valid;
   led_item_type                       mix_item;
   logic                               ser_ready;

   // register file
   assign csr_ready = 1'b1;
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_idx_type'(csr_index))
            CSR_CO2_LOW:    cfg_in.co2_low    = csr_wdata;
            CSR_CO2_HIGH:   cfg_in.co2_high   = csr_wdata;
            CSR_TVOC_LOW:   cfg_in.tvoc_low   = csr_wdata;
            CSR_TVOC_HIGH:  cfg_in.tvoc_high  = csr_wdata;
            CSR_BRIGHTNESS: cfg_in.brightness = csr_wdata[COLOR_W-1:0];
            CSR_SATURATION: cfg_in.saturation = csr_wdata[COLOR_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input stage
   assign req_stall = !front_ready;

   aqlb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_ready (div_ready),
      .out_lane  (front_lane)
   );

   // level dividers
   aqlb_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (div_ready),
      .in_lane   (front_lane),
      .out_valid (div_valid),
      .out_ready (mix_ready),
      .out_level (div_level)
   );

   // max, scale and edge split
   aqlb_mix #(
      .NUM_LEDS  (NUM_LEDS),
      .FRAC_BITS (FRAC_BITS)
   ) u_mix (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (div_valid),
      .in_ready  (mix_ready),
      .in_level  (div_level),
      .out_valid (mix_valid),
      .out_ready (ser_ready),
      .out_item  (mix_item)
   );

   // LED serializer and output register
   aqlb_serial #(
      .NUM_LEDS (NUM_LEDS)
   ) u_serial (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (mix_valid),
      .in_ready  (ser_ready),
      .in_item   (mix_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule : air_quality_led_bar_meter_top
`default_nettype wire

/* test/aqlb_bar_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aqlb_bar_checker
// Scoreboard for the air quality LED bar meter: tracks the register file from
// the CSR channel, predicts the LED colors of every accepted reading and
// compares each result transfer against the oldest predicted color.
// ----------------------------------------------------------------------------
module aqlb_bar_checker
   import aqlb_pkg::*;
#(
   parameter int NUM_LEDS  = NUM_LEDS_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   input  wire                  req_stall,
   input  req_type              req_data,
   input  wire                  rsp_valid,
   input  wire                  rsp_stall,
   input  rsp_type              rsp_data,
   input  wire                  csr_valid,
   input  wire                  csr_ready,
   input  wire [CSR_IDX_W-1:0]  csr_index,
   input  wire [CSR_DATA_W-1:0] csr_wdata,
   output int                   mismatch_count,
   output int                   pending_colors,
   output int                   reading_count,
   output int                   color_count
);

   // shadow of the register file and the colors still owed by the block
   cfg_type  meter_cfg;
   rsp_type  led_colors_due[$];
   int       errors;
   int       readings;
   int       colors;

   // fill level of one gas, fixed point with FRAC_BITS fraction bits
   function automatic logic [63:0] gas_fill(logic [63:0] v, logic [63:0] lo,
                                            logic [63:0] hi);
      logic [63:0] one;
      one = 64'd1 << FRAC_BITS;
      if (v < lo)
         return 64'd0;
      if (v < 2 * hi)
         return ((v - lo) << FRAC_BITS) / (2 * hi - lo);
      return one;
   endfunction

   // severity of one gas: zero below high, saturates at twice high
   function automatic logic [63:0] gas_severity(logic [63:0] v, logic [63:0] hi);
      logic [63:0] one;
      one = 64'd1 << FRAC_BITS;
      if (v < hi)
         return 64'd0;
      if (v < 2 * hi)
         return ((v - hi) << FRAC_BITS) / hi;
      return one;
   endfunction

   // work out the whole bar for one reading and queue its colors in LED order
   task automatic queue_bar_colors(req_type rd);
      logic [63:0] fill_co2;
      logic [63:0] fill_tvoc;
      logic [63:0] sev_co2;
      logic [63:0] sev_tvoc;
      logic [63:0] fill;
      logic [63:0] sev;
      logic [63:0] scaled;
      logic [63:0] edge_led;
      logic [63:0] frac;
      logic [63:0] hue_v;
      logic [63:0] edge_val;
      rsp_type     color;
      fill_co2  = gas_fill(64'(rd.co2_ppm), 64'(meter_cfg.co2_low),
                           64'(meter_cfg.co2_high));
      fill_tvoc = gas_fill(64'(rd.tvoc_ppb), 64'(meter_cfg.tvoc_low),
                           64'(meter_cfg.tvoc_high));
      sev_co2   = gas_severity(64'(rd.co2_ppm), 64'(meter_cfg.co2_high));
      sev_tvoc  = gas_severity(64'(rd.tvoc_ppb), 64'(meter_cfg.tvoc_high));
      fill      = (fill_co2 > fill_tvoc) ? fill_co2 : fill_tvoc;
      sev       = (sev_co2 > sev_tvoc) ? sev_co2 : sev_tvoc;
      scaled    = fill * 64'(NUM_LEDS);
      edge_led  = scaled >> FRAC_BITS;
      frac      = scaled - (edge_led << FRAC_BITS);
      hue_v     = (64'(HUE_RED) * sev) >> FRAC_BITS;
      edge_val  = (frac * 64'(meter_cfg.brightness)) >> FRAC_BITS;
      for (int k = 0; k < NUM_LEDS; k++) begin
         color.led_index = k[LED_IDX_W-1:0];
         // lit up to and including the edge LED, dark beyond it
         if (fill != 0 && 64'(k) <= edge_led) begin
            color.hue     = hue_v[HUE_W-1:0];
            color.sat_out = meter_cfg.saturation;
            color.val_out = (64'(k) < edge_led) ? meter_cfg.brightness
                                                 : edge_val[COLOR_W-1:0];
         end else begin
            color.hue     = '0;
            color.sat_out = '0;
            color.val_out = '0;
         end
         color.last = (k == NUM_LEDS - 1);
         led_colors_due.push_back(color);
      end
   endtask

   task automatic check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         errors++;
      end
   endtask

   // sample all three channels at the clock edge
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         meter_cfg = CFG_RESET;
         led_colors_due.delete();
         errors   = 0;
         readings = 0;
         colors   = 0;
      end else begin
         // register write transfer
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CO2_LOW:    meter_cfg.co2_low    = csr_wdata;
               CSR_CO2_HIGH:   meter_cfg.co2_high   = csr_wdata;
               CSR_TVOC_LOW:   meter_cfg.tvoc_low   = csr_wdata;
               CSR_TVOC_HIGH:  meter_cfg.tvoc_high  = csr_wdata;
               CSR_BRIGHTNESS: meter_cfg.brightness = csr_wdata[COLOR_W-1:0];
               CSR_SATURATION: meter_cfg.saturation = csr_wdata[COLOR_W-1:0];
               default: ;
            endcase
         end
         // reading transfer
         if (req_valid && !req_stall) begin
            queue_bar_colors(req_data);
            readings++;
         end
         // color transfer against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            colors++;
            if (led_colors_due.size() == 0) begin
               $error("unexpected LED color transfer, led_index %0d",
                      rsp_data.led_index);
               errors++;
            end else begin
               want = led_colors_due.pop_front();
               check_field("led_index", 32'(want.led_index),
                           32'(rsp_data.led_index));
               check_field("hue", 32'(want.hue), 32'(rsp_data.hue));
               check_field("sat_out", 32'(want.sat_out), 32'(rsp_data.sat_out));
               check_field("val_out", 32'(want.val_out), 32'(rsp_data.val_out));
               check_field("last", 32'(want.last), 32'(rsp_data.last));
            end
         end
      end
      mismatch_count <= errors;
      pending_colors <= led_colors_due.size();
      reading_count  <= readings;
      color_count    <= colors;
   end

endmodule : aqlb_bar_checker

/* test/air_quality_led_bar_meter_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// air_quality_led_bar_meter_top_tb
// Drives readings and register settings into the LED bar meter and lets the
// checker score every LED color; the run sweeps threshold extremes, random
// settings and three idle patterns, including a long result hold.
// ----------------------------------------------------------------------------
module air_quality_led_bar_meter_top_tb
   import aqlb_pkg::*;
();

   localparam int                   CYCLE_LIMIT    = 200000;
   localparam int                   HOLD_CYCLES    = 300;
   localparam int                   SETTLE_CYCLES  = FRAC_BITS_DEF + 2 * NUM_LEDS_DEF;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 3'd7;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   req_type               req_data  = '0;
   logic                  rsp_stall = 1'b0;
   logic                  csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_stall;
   logic                  rsp_valid;
   rsp_type               rsp_data;
   logic                  csr_ready;

   int      mismatch_count;
   int      pending_colors;
   int      reading_count;
   int      color_count;
   int      cycle_count    = 0;
   int      settings_count = 0;
   int      send_idle_pct  = 0;
   int      recv_stall_pct = 0;
   bit      hold_request   = 1'b0;
   cfg_type active_cfg     = CFG_RESET;

   air_quality_led_bar_meter_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   aqlb_bar_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_colors (pending_colors),
      .reading_count  (reading_count),
      .color_count    (color_count)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("air_quality_led_bar_meter_top_tb NOT OK");
      $finish;
   end

   // result side: random stall, or a long hold when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // one reading transfer, preceded by random idle cycles
   task automatic send_reading(logic [THR_W-1:0] co2, logic [THR_W-1:0] tvoc);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{co2_ppm: co2, tvoc_ppb: tvoc};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // stop offering readings until every predicted color has come back
   task automatic drain_colors();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_colors != 0);
   endtask

   // one register transfer; valid stays up for back-to-back writes
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // full register file, with junk in the upper bits of the 8 bit registers
   task automatic write_settings(cfg_type c);
      csr_write(CSR_UNUSED_IDX, 16'($urandom));
      csr_write(CSR_CO2_LOW, c.co2_low);
      csr_write(CSR_CO2_HIGH, c.co2_high);
      csr_write(CSR_TVOC_LOW, c.tvoc_low);
      csr_write(CSR_TVOC_HIGH, c.tvoc_high);
      csr_write(CSR_BRIGHTNESS, {8'($urandom), c.brightness});
      csr_write(CSR_SATURATION, {8'($urandom), c.saturation});
      csr_valid  <= 1'b0;
      active_cfg = c;
      settings_count++;
   endtask

   // reading biased toward the interesting part of one gas's range
   function automatic logic [THR_W-1:0] pick_reading(logic [THR_W-1:0] lo,
                                                     logic [THR_W-1:0] hi);
      int top;
      int base;
      top = 2 * int'(hi) + int'(hi) / 4 + 8;
      if (top > 65535)
         top = 65535;
      case ($urandom_range(3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(top));
         2: begin
            // near a breakpoint: low, high or twice high
            case ($urandom_range(2))
               0:       base = int'(lo);
               1:       base = int'(hi);
               default: base = 2 * int'(hi);
            endcase
            base = base + $urandom_range(6) - 3;
            if (base < 0)
               base = 0;
            if (base > 65535)
               base = 65535;
            return 16'(base);
         end
         default: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      endcase
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      if ($urandom_range(3) == 0) begin
         c.co2_low   = 16'($urandom);
         c.co2_high  = 16'($urandom);
         c.tvoc_low  = 16'($urandom);
         c.tvoc_high = 16'($urandom);
      end else begin
         c.co2_low   = 16'($urandom_range(4000));
         c.co2_high  = 16'($urandom_range(3000, 1));
         c.tvoc_low  = 16'($urandom_range(1000));
         c.tvoc_high = 16'($urandom_range(1500, 1));
      end
      c.brightness = 8'($urandom_range(255));
      c.saturation = 8'($urandom_range(255));
      return c;
   endfunction

   // write settings, send random readings, wait for the bar to drain
   task automatic run_phase(cfg_type c, int n, int s_pct, int r_pct, bit hold);
      write_settings(c);
      send_idle_pct  = s_pct;
      recv_stall_pct = r_pct;
      if (hold)
         hold_request = 1'b1;
      repeat (n)
         send_reading(pick_reading(active_cfg.co2_low, active_cfg.co2_high),
                      pick_reading(active_cfg.tvoc_low, active_cfg.tvoc_high));
      drain_colors();
   endtask

   // stimulus
   initial begin
      cfg_type zero_cfg;
      cfg_type wide_cfg;
      cfg_type tight_cfg;
      zero_cfg  = '{co2_low: 16'd0, co2_high: 16'd0, tvoc_low: 16'd0,
                    tvoc_high: 16'd0, brightness: 8'd255, saturation: 8'd0};
      wide_cfg  = '{co2_low: 16'd0, co2_high: 16'hFFFF, tvoc_low: 16'd0,
                    tvoc_high: 16'hFFFF, brightness: 8'd0, saturation: 8'd255};
      tight_cfg = '{co2_low: 16'hFFFF, co2_high: 16'd1, tvoc_low: 16'hFFFF,
                    tvoc_high: 16'd1, brightness: 8'd1, saturation: 8'd128};

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed readings on reset thresholds
      send_idle_pct  = 27;
      recv_stall_pct = 46;
      send_reading(16'd0, 16'd0);          // dark bar
      send_reading(16'hFFFF, 16'hFFFF);    // full bar, full red
      send_reading(16'd999, 16'd219);      // just below low
      send_reading(16'd1000, 16'd220);     // at low, still dark
      send_reading(16'd1001, 16'd0);       // tiny fill, edge LED 0 lit at zero value
      send_reading(16'd1750, 16'd0);       // edge on a LED boundary
      send_reading(16'd2500, 16'd0);       // half bar, boundary edge, some severity
      send_reading(16'd1999, 16'd0);
      send_reading(16'd2000, 16'd0);       // severity starts
      send_reading(16'd3999, 16'd0);
      send_reading(16'd4000, 16'd0);       // exactly twice high
      send_reading(16'd0, 16'd495);        // tvoc edge on a boundary
      send_reading(16'd0, 16'd659);
      send_reading(16'd0, 16'd660);
      send_reading(16'd0, 16'd1319);
      send_reading(16'd0, 16'd1320);
      send_reading(16'd3000, 16'd1000);
      send_reading(16'hAAAA, 16'h5555);
      send_reading(16'h5555, 16'hAAAA);
      send_reading(16'd1500, 16'd800);
      send_reading(16'd2200, 16'd900);
      send_reading(16'd1200, 16'd300);
      drain_colors();

      // sender idles 27%, receiver 46%; the held phase overfills the pipeline
      run_phase(zero_cfg, 6, 27, 46, 1'b0);
      run_phase(wide_cfg, 6, 27, 46, 1'b0);
      run_phase(random_settings(), 30, 27, 46, 1'b1);
      // swapped idle rates
      run_phase(random_settings(), 12, 46, 27, 1'b0);
      run_phase(tight_cfg, 6, 46, 27, 1'b0);
      // no idling at all
      run_phase(random_settings(), 12, 0, 0, 1'b0);
      run_phase(CFG_RESET, 6, 0, 0, 1'b0);

      // catch any stray colors
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("checked %0d readings and %0d LED colors under %0d register settings,",
               reading_count, color_count, settings_count);
      $display("with threshold extremes, a long result hold and three idle patterns");
      if (mismatch_count == 0 && pending_colors == 0)
         $display("air_quality_led_bar_meter_top_tb OK");
      else
         $display("air_quality_led_bar_meter_top_tb NOT OK");
      $finish;
   end

endmodule : air_quality_led_bar_meter_top_tb
